>>> rtl/narss_pkg.sv
// shared types and constants for the no-adjacent-repeat symbol scheduler
// depends on nothing; used by narss_scan and the top level
package narss_pkg;

   localparam int ALPHABET_SIZE = 26;
   localparam int COUNT_WIDTH   = 16;
   localparam int SYM_W         = 5;
   localparam int IDX_W         = $clog2(ALPHABET_SIZE);

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [IDX_W-1:0]       idx_type;

   // sequencer to compare unit
   typedef struct packed {
      logic    clear;
      logic    step;
      logic    exclude_valid;
      idx_type exclude;
      idx_type idx;
   } scan_ctrl_type;

   // compare unit back to sequencer
   typedef struct packed {
      logic    found;
      logic    leftover;
      idx_type best;
   } scan_status_type;

endpackage

>>> rtl/narss_scan.sv
// shared compare unit: keeps the running maximum over one count per cycle while step is high
// depends on narss_pkg
module narss_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  narss_pkg::scan_ctrl_type    ctrl,
   input  narss_pkg::count_type        count,
   output narss_pkg::scan_status_type  status
);

   logic                 found_ff, found_in;
   logic                 leftover_ff, leftover_in;
   narss_pkg::idx_type   best_ff, best_in;
   narss_pkg::count_type best_count_ff, best_count_in;
   logic                 nonzero;
   logic                 eligible;
   logic                 take;

   assign nonzero  = (count != '0);
   assign eligible = nonzero && !(ctrl.exclude_valid && (ctrl.idx == ctrl.exclude));
   // ties go to the larger index since the scan runs upward
   assign take     = eligible && (!found_ff || (count >= best_count_ff));

   always_comb begin
      found_in      = found_ff;
      leftover_in   = leftover_ff;
      best_in       = best_ff;
      best_count_in = best_count_ff;
      if (ctrl.clear) begin
         found_in    = 1'b0;
         leftover_in = 1'b0;
      end else if (ctrl.step) begin
         leftover_in = leftover_ff | nonzero;
         if (take) begin
            found_in      = 1'b1;
            best_in       = ctrl.idx;
            best_count_in = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff    <= 1'b0;
         leftover_ff <= 1'b0;
      end else begin
         found_ff    <= found_in;
         leftover_ff <= leftover_in;
      end
      best_ff       <= best_in;
      best_count_ff <= best_count_in;
   end

   assign status.found    = found_ff;
   assign status.leftover = leftover_ff;
   assign status.best     = best_ff;

endmodule

>>> rtl/no_adjacent_repeat_symbol_scheduler_top.sv
// top level of the no-adjacent-repeat symbol scheduler: histogram, sequencer, result register
// depends on narss_pkg and narss_scan
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  request  | start && !busy         | req_cmd, req_symbol_in
//  response | rsp_strobe (one cycle) | rsp_symbol_out, rsp_symbol_valid,
//           |                        | rsp_finished, rsp_impossible
//
// an add item is taken without raising busy; an add gives no result.
// a pull item holds busy while it reads one count per cycle through the
// single compare unit and then makes its update; its result strobes in the next cycle.
// synchronous reset clears the histogram, the last-symbol mark and the sequencer.
// the receiver cannot stall: each result is strobed for exactly one cycle.
module no_adjacent_repeat_symbol_scheduler_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_cmd,
   input  logic [narss_pkg::SYM_W-1:0]  req_symbol_in,
   output logic                         rsp_strobe,
   output logic [narss_pkg::SYM_W-1:0]  rsp_symbol_out,
   output logic                         rsp_symbol_valid,
   output logic                         rsp_finished,
   output logic                         rsp_impossible
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   narss_pkg::idx_type          idx_ff, idx_in;
   narss_pkg::idx_type          last_ff, last_in;
   logic                        last_valid_ff, last_valid_in;
   narss_pkg::count_type        counts_ff [narss_pkg::ALPHABET_SIZE];
   narss_pkg::count_type        counts_in [narss_pkg::ALPHABET_SIZE];
   logic                        strobe_ff, strobe_in;
   logic [narss_pkg::SYM_W-1:0] sym_out_ff, sym_out_in;
   logic                        sym_valid_ff, sym_valid_in;
   logic                        finished_ff, finished_in;
   logic                        impossible_ff, impossible_in;

   logic                        accept;
   logic                        sym_ok;
   narss_pkg::idx_type          rd_addr;
   narss_pkg::count_type        rd_count;
   logic                        wr_en;
   narss_pkg::count_type        wr_data;
   logic                        clear_all;
   narss_pkg::scan_ctrl_type    scan_ctrl;
   narss_pkg::scan_status_type  scan_status;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);
   assign sym_ok = (int'(req_symbol_in) < narss_pkg::ALPHABET_SIZE);

   // single read port: add symbol, scan position or chosen symbol
   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = narss_pkg::IDX_W'(req_symbol_in);
         ST_SCAN: rd_addr = idx_ff;
         ST_DONE: rd_addr = scan_status.best;
         default: rd_addr = idx_ff;
      endcase
   end
   assign rd_count = counts_ff[rd_addr];

   assign scan_ctrl.clear         = accept;
   assign scan_ctrl.step          = (state_ff == ST_SCAN);
   assign scan_ctrl.exclude_valid = last_valid_ff;
   assign scan_ctrl.exclude       = last_ff;
   assign scan_ctrl.idx           = idx_ff;

   narss_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (scan_ctrl),
      .count  (rd_count),
      .status (scan_status)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      last_valid_in = last_valid_ff;
      strobe_in     = 1'b0;
      sym_out_in    = sym_out_ff;
      sym_valid_in  = sym_valid_ff;
      finished_in   = finished_ff;
      impossible_in = impossible_ff;
      wr_en         = 1'b0;
      wr_data       = rd_count;
      clear_all     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == narss_pkg::CMD_ADD) begin
                  // saturate at the count width
                  if (sym_ok && !(&rd_count)) begin
                     wr_en   = 1'b1;
                     wr_data = rd_count + narss_pkg::COUNT_WIDTH'(1);
                  end
               end else begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + narss_pkg::IDX_W'(1);
            if (idx_ff == narss_pkg::IDX_W'(narss_pkg::ALPHABET_SIZE - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
            if (scan_status.found) begin
               wr_en         = 1'b1;
               wr_data       = rd_count - narss_pkg::COUNT_WIDTH'(1);
               last_in       = scan_status.best;
               last_valid_in = 1'b1;
               sym_out_in    = narss_pkg::SYM_W'(scan_status.best);
               sym_valid_in  = 1'b1;
               finished_in   = 1'b0;
               impossible_in = 1'b0;
            end else begin
               clear_all     = 1'b1;
               last_in       = '0;
               last_valid_in = 1'b0;
               sym_out_in    = '0;
               sym_valid_in  = 1'b0;
               finished_in   = 1'b1;
               impossible_in = scan_status.leftover;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < narss_pkg::ALPHABET_SIZE; i++) begin
         if (clear_all) begin
            counts_in[i] = '0;
         end else if (wr_en && (rd_addr == narss_pkg::IDX_W'(i))) begin
            counts_in[i] = wr_data;
         end else begin
            counts_in[i] = counts_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ff       <= '0;
         last_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
         for (int i = 0; i < narss_pkg::ALPHABET_SIZE; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         last_valid_ff <= last_valid_in;
         strobe_ff     <= strobe_in;
         for (int i = 0; i < narss_pkg::ALPHABET_SIZE; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
      idx_ff        <= idx_in;
      sym_out_ff    <= sym_out_in;
      sym_valid_ff  <= sym_valid_in;
      finished_ff   <= finished_in;
      impossible_ff <= impossible_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_symbol_out   = sym_out_ff;
   assign rsp_symbol_valid = sym_valid_ff;
   assign rsp_finished     = finished_ff;
   assign rsp_impossible   = impossible_ff;

   // a result is either a symbol or the end of the sequence, never both
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_symbol_valid != rsp_finished))
      else $error("result is neither or both symbol and finished");

   a_impossible_needs_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_impossible) |-> rsp_finished)
      else $error("impossible flagged without finished");

   // an emitted symbol never repeats the one before it
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && scan_status.found && last_valid_ff)
         |-> (scan_status.best != last_ff))
      else $error("chosen symbol repeats the last emitted one");

   a_pull_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == narss_pkg::CMD_PULL) |=> busy)
      else $error("pull item did not start a scan");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_DONE))
      else $error("result strobe without an update cycle");

endmodule
